>>> hw/rtl/hsv_to_rgb_converter_core_macros.svh
// Assertion macros for the HSV to RGB converter core.
// No dependencies; included by the top level.
`ifndef HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH

// Check a property while out of reset.
`define HSV2RGB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define HSV2RGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter pipeline.
// No dependencies.
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int LEVEL_W = 8;
    localparam int PROD_W  = 14;
    localparam int TERM_W  = 20;
    localparam int Y_W     = 18;
    localparam int RECIP_W = 19;
    localparam int K_W     = 6;

    localparam logic [PCT_W-1:0]   FULL_PCT   = 7'd100;
    localparam logic [K_W-1:0]     DEG_SECTOR = 6'd60;
    localparam logic [RECIP_W-1:0] RECIP_625  = 19'd429497;
    localparam int                 RECIP_SHIFT = 28;

    localparam logic [2:0] SEC_RED_YEL  = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
    localparam logic [2:0] SEC_MAG_RED  = 3'd5;

    typedef struct packed {
        logic [2:0] sector;
        logic       grey;
    } t_ctrl;

    typedef struct packed {
        logic [Y_W-1:0] lo;
        logic [Y_W-1:0] mid;
        logic [Y_W-1:0] hi;
    } t_lanes;

    typedef struct packed {
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] mid;
        logic [LEVEL_W-1:0] hi;
    } t_levels;

endpackage

`default_nettype wire

>>> hw/rtl/hsv2rgb_front.sv
// First stage: clamp, chroma product, hue sector and intermediate weight.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_front
    import hsv2rgb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [HUE_W-1:0]  i_hue,
    input  wire logic [PCT_W-1:0]  i_sat,
    input  wire logic [PCT_W-1:0]  i_val,
    output logic                   o_valid,
    output logic [PROD_W-1:0]      o_chroma,
    output logic [PROD_W-1:0]      o_vfull,
    output logic [K_W-1:0]         o_k,
    output t_ctrl                  o_ctrl
);

    logic [PCT_W-1:0]  sat_c;
    logic [PCT_W-1:0]  val_c;
    logic [HUE_W-1:0]  base;
    logic [HUE_W-1:0]  off_full;
    logic [K_W-1:0]    off;
    t_ctrl             n_ctrl;
    logic [K_W-1:0]    n_k;

    logic              r_valid;
    logic [PROD_W-1:0] r_chroma;
    logic [PROD_W-1:0] r_vfull;
    logic [K_W-1:0]    r_k;
    t_ctrl             r_ctrl;

    always_comb begin
        sat_c = (i_sat > FULL_PCT) ? FULL_PCT : i_sat;
        val_c = (i_val > FULL_PCT) ? FULL_PCT : i_val;
        n_ctrl.grey = 1'b0;
        priority if (i_hue < 9'd60) begin
            n_ctrl.sector = SEC_RED_YEL;
            base = 9'd0;
        end else if (i_hue < 9'd120) begin
            n_ctrl.sector = SEC_YEL_GRN;
            base = 9'd60;
        end else if (i_hue < 9'd180) begin
            n_ctrl.sector = SEC_GRN_CYN;
            base = 9'd120;
        end else if (i_hue < 9'd240) begin
            n_ctrl.sector = SEC_CYN_BLU;
            base = 9'd180;
        end else if (i_hue < 9'd300) begin
            n_ctrl.sector = SEC_BLU_MAG;
            base = 9'd240;
        end else if (i_hue < 9'd360) begin
            n_ctrl.sector = SEC_MAG_RED;
            base = 9'd300;
        end else begin
            n_ctrl.sector = SEC_RED_YEL;
            n_ctrl.grey   = 1'b1;
            base = 9'd0;
        end
        off_full = i_hue - base;
        off      = off_full[K_W-1:0];
        n_k      = n_ctrl.sector[0] ? (DEG_SECTOR - off) : off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chroma <= PROD_W'(val_c * sat_c);
            r_vfull  <= PROD_W'(val_c * FULL_PCT);
            r_k      <= n_k;
            r_ctrl   <= n_ctrl;
        end
    end

    assign o_valid  = r_valid;
    assign o_chroma = r_chroma;
    assign o_vfull  = r_vfull;
    assign o_k      = r_k;
    assign o_ctrl   = r_ctrl;

endmodule

`default_nettype wire

>>> hw/rtl/hsv2rgb_terms.sv
// Second and third stages: minimum and weighted chroma products, then the
// three channel terms scaled by 17/64. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_terms
    import hsv2rgb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [PROD_W-1:0] i_chroma,
    input  wire logic [PROD_W-1:0] i_vfull,
    input  wire logic [K_W-1:0]    i_k,
    input  wire t_ctrl             i_ctrl,
    output logic                   o_valid,
    output t_lanes                 o_lanes,
    output t_ctrl                  o_ctrl
);

    logic [PROD_W-1:0] min_lvl;
    logic [TERM_W-1:0] t_lo;
    logic [TERM_W-1:0] t_mid;
    logic [TERM_W-1:0] t_hi;
    logic [23:0]       x_lo;
    logic [23:0]       x_mid;
    logic [23:0]       x_hi;

    logic              r_valid_a;
    logic [TERM_W-1:0] r_m60;
    logic [TERM_W-1:0] r_ck;
    logic [TERM_W-1:0] r_c60;
    t_ctrl             r_ctrl_a;

    logic              r_valid_b;
    t_lanes            r_lanes;
    t_ctrl             r_ctrl_b;

    assign min_lvl = i_vfull - i_chroma;

    always_comb begin
        t_lo  = r_m60;
        t_mid = r_m60 + r_ck;
        t_hi  = r_m60 + r_c60;
        x_lo  = {t_lo,  4'd0} + {4'd0, t_lo};
        x_mid = {t_mid, 4'd0} + {4'd0, t_mid};
        x_hi  = {t_hi,  4'd0} + {4'd0, t_hi};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m60     <= TERM_W'(min_lvl * DEG_SECTOR);
            r_ck      <= TERM_W'(i_chroma * i_k);
            r_c60     <= TERM_W'(i_chroma * DEG_SECTOR);
            r_ctrl_a  <= i_ctrl;
            r_lanes.lo  <= x_lo[Y_W+5:6];
            r_lanes.mid <= x_mid[Y_W+5:6];
            r_lanes.hi  <= x_hi[Y_W+5:6];
            r_ctrl_b  <= r_ctrl_a;
        end
    end

    assign o_valid = r_valid_b;
    assign o_lanes = r_lanes;
    assign o_ctrl  = r_ctrl_b;

endmodule

`default_nettype wire

>>> hw/rtl/hsv2rgb_scale.sv
// Fourth stage: divide each lane by 625 through a reciprocal product.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_scale
    import hsv2rgb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_lanes i_lanes,
    input  wire t_ctrl  i_ctrl,
    output logic        o_valid,
    output t_levels     o_levels,
    output t_ctrl       o_ctrl
);

    localparam int P_W = Y_W + RECIP_W;

    logic [P_W-1:0] p_lo;
    logic [P_W-1:0] p_mid;
    logic [P_W-1:0] p_hi;

    logic    r_valid;
    t_levels r_levels;
    t_ctrl   r_ctrl;

    always_comb begin
        p_lo  = P_W'(i_lanes.lo)  * P_W'(RECIP_625);
        p_mid = P_W'(i_lanes.mid) * P_W'(RECIP_625);
        p_hi  = P_W'(i_lanes.hi)  * P_W'(RECIP_625);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_levels.lo  <= p_lo[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
            r_levels.mid <= p_mid[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
            r_levels.hi  <= p_hi[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
            r_ctrl       <= i_ctrl;
        end
    end

    assign o_valid  = r_valid;
    assign o_levels = r_levels;
    assign o_ctrl   = r_ctrl;

endmodule

`default_nettype wire

>>> hw/rtl/hsv_to_rgb_converter_core.sv
// HSV to RGB converter, top level: stream ports, stall control, channel
// routing and output register. Depends on hsv2rgb_pkg, the pipeline stages
// and hsv_to_rgb_converter_core_macros.svh.
//
// Usage:
//   Slave channel takes one pixel per item: hue in degrees, saturation and
//   value in percent. Master channel gives 8-bit red, green and blue.
//   Saturation or value above 100 counts as 100; hue of 360 or more gives
//   grey at the minimum level.
//   Results reach the master side through the five register stages
//   (sector, products, terms, reciprocal divide, channel routing); one item
//   is taken per cycle while the receiver does not stall the output.
//   Every stage advances together whenever the output register is empty or
//   being taken, so o_s_axis_tready follows i_m_axis_tready while the
//   output holds an item. A stalled receiver freezes the whole pipeline;
//   nothing is dropped or repeated.
//   Reset clears every valid bit; the block accepts items as soon as reset
//   is released.
`default_nettype none
`include "hsv_to_rgb_converter_core_macros.svh"

module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [8:0] hue_degrees, [15:9] saturation_pct, [22:16] value_pct, [23] zero
    input  wire logic [23:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] red_level, [15:8] green_level, [23:16] blue_level
    output logic [23:0]      o_m_axis_tdata
);

    logic              adv;
    logic              f_valid;
    logic [PROD_W-1:0] f_chroma;
    logic [PROD_W-1:0] f_vfull;
    logic [K_W-1:0]    f_k;
    t_ctrl             f_ctrl;
    logic              t_valid;
    t_lanes            t_lanes_q;
    t_ctrl             t_ctrl_q;
    logic              s_valid;
    t_levels           s_levels;
    t_ctrl             s_ctrl;

    logic [LEVEL_W-1:0] n_red;
    logic [LEVEL_W-1:0] n_green;
    logic [LEVEL_W-1:0] n_blue;

    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_red;
    logic [LEVEL_W-1:0] r_green;
    logic [LEVEL_W-1:0] r_blue;
    t_ctrl              r_ctrl;

    assign adv = !r_out_valid || i_m_axis_tready;

    hsv2rgb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (i_s_axis_tvalid),
        .i_hue    (i_s_axis_tdata[8:0]),
        .i_sat    (i_s_axis_tdata[15:9]),
        .i_val    (i_s_axis_tdata[22:16]),
        .o_valid  (f_valid),
        .o_chroma (f_chroma),
        .o_vfull  (f_vfull),
        .o_k      (f_k),
        .o_ctrl   (f_ctrl)
    );

    hsv2rgb_terms u_terms (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (f_valid),
        .i_chroma (f_chroma),
        .i_vfull  (f_vfull),
        .i_k      (f_k),
        .i_ctrl   (f_ctrl),
        .o_valid  (t_valid),
        .o_lanes  (t_lanes_q),
        .o_ctrl   (t_ctrl_q)
    );

    hsv2rgb_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (t_valid),
        .i_lanes  (t_lanes_q),
        .i_ctrl   (t_ctrl_q),
        .o_valid  (s_valid),
        .o_levels (s_levels),
        .o_ctrl   (s_ctrl)
    );

    always_comb begin
        if (s_ctrl.grey) begin
            n_red   = s_levels.lo;
            n_green = s_levels.lo;
            n_blue  = s_levels.lo;
        end else begin
            unique case (s_ctrl.sector)
                SEC_RED_YEL: begin
                    n_red = s_levels.hi;  n_green = s_levels.mid; n_blue = s_levels.lo;
                end
                SEC_YEL_GRN: begin
                    n_red = s_levels.mid; n_green = s_levels.hi;  n_blue = s_levels.lo;
                end
                SEC_GRN_CYN: begin
                    n_red = s_levels.lo;  n_green = s_levels.hi;  n_blue = s_levels.mid;
                end
                SEC_CYN_BLU: begin
                    n_red = s_levels.lo;  n_green = s_levels.mid; n_blue = s_levels.hi;
                end
                SEC_BLU_MAG: begin
                    n_red = s_levels.mid; n_green = s_levels.lo;  n_blue = s_levels.hi;
                end
                default: begin
                    n_red = s_levels.hi;  n_green = s_levels.lo;  n_blue = s_levels.mid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_ctrl  <= s_ctrl;
        end
    end

    assign o_s_axis_tready = adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_blue, r_green, r_red};

    `HSV2RGB_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")
    `HSV2RGB_ASSERT(a_grey_equal, i_clk, i_rst_n, (r_out_valid && r_ctrl.grey) |-> (r_red == r_green && r_green == r_blue), "grey pixel has unequal channels")
    `HSV2RGB_ASSERT(a_red_sector_order, i_clk, i_rst_n, (r_out_valid && !r_ctrl.grey && r_ctrl.sector == SEC_RED_YEL) |-> (r_red >= r_green && r_green >= r_blue), "channel order broken in red sector")
    `HSV2RGB_ASSERT(a_stall_freezes, i_clk, i_rst_n, (r_out_valid && !i_m_axis_tready) |=> $stable(s_levels) && $stable(s_valid), "pipeline moved during stall")

endmodule

`default_nettype wire

>>> tb/hsv_to_rgb_converter_core_tb.sv
// Self-checking bench for hsv_to_rgb_converter_core: directed corner pixels, then random
// pixels under changing stream back-pressure, each result checked against a bit-exact predictor.
// Depends on hsv2rgb_pkg and the converter RTL only.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_core_tb;
    import hsv2rgb_pkg::*;

    localparam int CYCLE_LIMIT = 60000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } t_rgb;

    class rgb_ledger;
        t_rgb rgb_due[$];
        int   mismatches;
        int   matched;

        function new();
            mismatches = 0;
            matched    = 0;
        endfunction

        static function logic [LEVEL_W-1:0] scale_level(int unsigned m60, int unsigned chroma,
                                                         int unsigned w);
            int unsigned t;
            t = m60 + chroma * w;
            return LEVEL_W'((t * 255) / 600000);
        endfunction

        static function t_rgb hsv_to_rgb(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                                         logic [PCT_W-1:0] val);
            int unsigned s, v, c, m60, r, d, k;
            logic [LEVEL_W-1:0] lo, mid, hi;
            t_rgb px;
            s   = (sat > FULL_PCT) ? FULL_PCT : sat;
            v   = (val > FULL_PCT) ? FULL_PCT : val;
            c   = v * s;
            m60 = (v * FULL_PCT - c) * DEG_SECTOR;
            r   = hue % (2 * DEG_SECTOR);
            d   = (r >= DEG_SECTOR) ? r - DEG_SECTOR : DEG_SECTOR - r;
            k   = DEG_SECTOR - d;
            lo  = scale_level(m60, c, 0);
            mid = scale_level(m60, c, k);
            hi  = scale_level(m60, c, DEG_SECTOR);
            if (hue >= 6 * DEG_SECTOR) begin
                px = '{lo, lo, lo};
            end else begin
                case (3'(hue / DEG_SECTOR))
                    SEC_RED_YEL: px = '{blue: lo,  green: mid, red: hi};
                    SEC_YEL_GRN: px = '{blue: lo,  green: hi,  red: mid};
                    SEC_GRN_CYN: px = '{blue: mid, green: hi,  red: lo};
                    SEC_CYN_BLU: px = '{blue: hi,  green: mid, red: lo};
                    SEC_BLU_MAG: px = '{blue: hi,  green: lo,  red: mid};
                    default:     px = '{blue: mid, green: lo,  red: hi};
                endcase
            end
            return px;
        endfunction

        function void note_pixel(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                                 logic [PCT_W-1:0] val);
            rgb_due.push_back(hsv_to_rgb(hue, sat, val));
        endfunction

        function void check_pixel(logic [23:0] data);
            t_rgb got, want;
            got = data;
            if (rgb_due.size() == 0) begin
                $error("unexpected result item 0x%06h", data);
                mismatches++;
            end else begin
                want = rgb_due.pop_front();
                if (got.red !== want.red) begin
                    $error("red_level: expected %0d, got %0d", want.red, got.red);
                    mismatches++;
                end
                if (got.green !== want.green) begin
                    $error("green_level: expected %0d, got %0d", want.green, got.green);
                    mismatches++;
                end
                if (got.blue !== want.blue) begin
                    $error("blue_level: expected %0d, got %0d", want.blue, got.blue);
                    mismatches++;
                end
                matched++;
            end
        endfunction

        function int pending();
            return rgb_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // [8:0] hue_degrees, [15:9] saturation_pct, [22:16] value_pct, [23] zero
    logic [23:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [7:0] red_level, [15:8] green_level, [23:16] blue_level
    logic [23:0] o_m_axis_tdata;

    rgb_ledger ledger = new();
    int  recv_idle_pct = 0;
    int  hold_left     = 0;
    bit  long_hold_due = 1'b0;
    int  cycle_count   = 0;
    int  directed_sent = 0;
    int  random_sent   = 0;

    hsv_to_rgb_converter_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("hsv_to_rgb_converter_core test failed");
            $finish;
        end
    end

    // Receiver: check accepted items, then pick next tready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            ledger.check_pixel(o_m_axis_tdata);
        if (long_hold_due) begin
            hold_left     = LONG_HOLD;
            long_hold_due = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_pixel(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                              logic [PCT_W-1:0] val, int send_idle_pct);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, val, sat, hue};
        do @(posedge i_clk); while (!o_s_axis_tready);
        ledger.note_pixel(hue, sat, val);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_directed(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                                 logic [PCT_W-1:0] val);
        send_pixel(hue, sat, val, 0);
        directed_sent++;
    endtask

    task automatic run_random(int n, int send_idle_pct, int recv_pct, bit with_hold);
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat, val;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n; i++) begin
            hue = HUE_W'(($urandom_range(9) == 0) ? $urandom_range(360, 511)
                                                  : $urandom_range(0, 359));
            sat = PCT_W'(($urandom_range(9) == 0) ? $urandom_range(101, 127)
                                                  : $urandom_range(0, 100));
            val = PCT_W'(($urandom_range(9) == 0) ? $urandom_range(101, 127)
                                                  : $urandom_range(0, 100));
            if (with_hold && i == 40)
                long_hold_due = 1'b1;
            send_pixel(hue, sat, val, send_idle_pct);
            random_sent++;
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sector edges at full saturation and value
        send_directed(9'd0,   7'd100, 7'd100);
        send_directed(9'd59,  7'd100, 7'd100);
        send_directed(9'd60,  7'd100, 7'd100);
        send_directed(9'd119, 7'd100, 7'd100);
        send_directed(9'd120, 7'd100, 7'd100);
        send_directed(9'd179, 7'd100, 7'd100);
        send_directed(9'd180, 7'd100, 7'd100);
        send_directed(9'd239, 7'd100, 7'd100);
        send_directed(9'd240, 7'd100, 7'd100);
        send_directed(9'd299, 7'd100, 7'd100);
        send_directed(9'd300, 7'd100, 7'd100);
        send_directed(9'd359, 7'd100, 7'd100);
        // Grey for hue at or above a full turn
        send_directed(9'd360, 7'd80,  7'd90);
        send_directed(9'd511, 7'd127, 7'd127);
        // Zero saturation, zero value, clamps and mid-range pixels
        send_directed(9'd200, 7'd0,   7'd100);
        send_directed(9'd45,  7'd100, 7'd0);
        send_directed(9'd0,   7'd0,   7'd0);
        send_directed(9'd90,  7'd127, 7'd127);
        send_directed(9'd150, 7'd101, 7'd50);
        send_directed(9'd270, 7'd50,  7'd101);
        send_directed(9'd30,  7'd50,  7'd75);
        send_directed(9'd330, 7'd1,   7'd1);
        send_directed(9'd256, 7'd64,  7'd64);
        drain();

        run_random(180, 7, 72, 1'b0);
        drain();
        run_random(180, 72, 7, 1'b0);
        drain();
        run_random(190, 0, 0, 1'b1);
        drain();

        $display("Ran %0d directed and %0d random pixels, %0d results checked, %0d mismatches,",
                 directed_sent, random_sent, ledger.matched, ledger.mismatches);
        $display("under three idling mixes, a %0d-cycle output stall and drained pauses.",
                 LONG_HOLD);
        if (ledger.mismatches == 0)
            $display("hsv_to_rgb_converter_core test passed");
        else
            $display("hsv_to_rgb_converter_core test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_front.sv
hw/rtl/hsv2rgb_terms.sv
hw/rtl/hsv2rgb_scale.sv
hw/rtl/hsv_to_rgb_converter_core.sv
tb/hsv_to_rgb_converter_core_tb.sv
